@@ hw/rtl/aip_pkg.sv @@
// Shared types and constants for the ASCII integer parser.
package aip_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] LETTER_OFFSET = 8'd10;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_STOP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic       is_space;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic       is_digit;
        logic [5:0] digit;
    } char_class_t;

endpackage

@@ hw/rtl/ascii_integer_parser.sv @@
// Top level of the streaming ASCII integer parser.
//
// The parser takes one character word per clock cycle and returns one result
// word for every string, on the word that carries last. A character is held in
// an input register and is stepped through the parse state when it leaves that
// register, where one multiply-add of the accumulator by the active base runs
// between the input register and the state and result registers; the result of
// a string is registered as its final character leaves the input register. Input
// is refused only when a final character waits behind a result not yet taken.
// number_base may be written only while no string is in progress.
module ascii_integer_parser #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [5:0]            number_base,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value,
    output logic [COUNT_BITS-1:0] end_offset,
    output logic                  any_digits
);

    logic [5:0]            base_reg;
    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_ch_reg;
    logic                  s1_last_reg;
    logic                  s1_go;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] offset_reg;
    logic                  digits_reg;

    aip_pkg::char_class_t  cls;
    logic [VALUE_BITS-1:0] res_value;
    logic [COUNT_BITS-1:0] res_offset;
    logic                  res_digits;

    assign cfg_ready  = 1'b1;
    assign s1_go      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_go;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_offset = offset_reg;
    assign any_digits = digits_reg;

    aip_digit u_digit (
        .ch  (s1_ch_reg),
        .cls (cls)
    );

    aip_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_go),
        .last        (s1_last_reg),
        .cls         (cls),
        .number_base (base_reg),
        .res_value   (res_value),
        .res_offset  (res_offset),
        .res_digits  (res_digits)
    );

    always_comb
    begin
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_go && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= aip_pkg::BASE_AUTO;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                base_reg <= number_base;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_ch_reg   <= ch;
            s1_last_reg <= last;
        end
        if (s1_go && s1_last_reg)
        begin
            value_reg  <= res_value;
            offset_reg <= res_offset;
            digits_reg <= res_digits;
        end
    end

    a_offset_needs_digit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !any_digits) |-> (end_offset == '0)
    ) else $error("end_offset is nonzero without any digit");

    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready)
    ) else $error("input refused without a blocked final character");

    a_result_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !(s1_go && s1_last_reg)) |=> !out_valid
    ) else $error("result word repeated after it was taken");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(s1_go && s1_last_reg)
    ) else $error("pending result word overwritten");

endmodule

@@ hw/rtl/aip_digit.sv @@
// Character classifier: whitespace, sign, prefix and digit value.
module aip_digit (
    input  logic [7:0]           ch,
    output aip_pkg::char_class_t cls
);

    logic [7:0] folded;
    logic [7:0] dec_val;
    logic [7:0] alpha_val;

    always_comb
    begin
        folded    = ch | aip_pkg::CH_CASE;
        dec_val   = ch - aip_pkg::CH_ZERO;
        alpha_val = folded - aip_pkg::CH_LOW_A + aip_pkg::LETTER_OFFSET;

        cls.is_space = (ch == aip_pkg::CH_SPACE) || (ch == aip_pkg::CH_TAB) ||
                       (ch == aip_pkg::CH_LF) || (ch == aip_pkg::CH_CR) ||
                       (ch == aip_pkg::CH_FF) || (ch == aip_pkg::CH_VT);
        cls.is_minus = (ch == aip_pkg::CH_MINUS);
        cls.is_plus  = (ch == aip_pkg::CH_PLUS);
        cls.is_zero  = (ch == aip_pkg::CH_ZERO);
        cls.is_x     = (folded == aip_pkg::CH_LOW_X);

        if ((ch >= aip_pkg::CH_ZERO) && (ch <= aip_pkg::CH_NINE))
        begin
            cls.is_digit = 1'b1;
            cls.digit    = dec_val[5:0];
        end
        else if ((folded >= aip_pkg::CH_LOW_A) && (folded <= aip_pkg::CH_LOW_Z))
        begin
            cls.is_digit = 1'b1;
            cls.digit    = alpha_val[5:0];
        end
        else
        begin
            cls.is_digit = 1'b0;
            cls.digit    = 6'd0;
        end
    end

endmodule

@@ hw/rtl/aip_core.sv @@
// Parse state, per-character step logic and result formation.
module aip_core #(
    parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = aip_pkg::COUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    last,
    input  aip_pkg::char_class_t    cls,
    input  logic [5:0]              number_base,
    output logic [VALUE_BITS-1:0]   res_value,
    output logic [COUNT_BITS-1:0]   res_offset,
    output logic                    res_digits
);

    localparam int PROD_BITS = VALUE_BITS + 6;

    aip_pkg::phase_t         phase_reg, phase_next, step_phase;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next, step_acc;
    logic                    neg_reg, neg_next, step_neg;
    logic [5:0]              base_reg, base_next, step_base;
    logic                    seen_reg, seen_next, step_seen;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next, consumed;
    logic [COUNT_BITS-1:0]   stop_reg, stop_next, step_stop;

    logic                    zero_pref;
    logic                    sign_char;
    logic [5:0]              pref_base;
    logic [5:0]              zero_base;
    logic                    do_digit;
    logic [5:0]              dbase;
    logic                    dig_ok;
    logic                    take;
    logic [PROD_BITS-1:0]    mac;
    logic                    res_seen;

    always_comb
    begin
        consumed  = (cnt_reg == {COUNT_BITS{1'b1}}) ? cnt_reg : cnt_reg + COUNT_BITS'(1);
        zero_pref = cls.is_zero &&
                    ((number_base == aip_pkg::BASE_AUTO) || (number_base == aip_pkg::BASE_HEX));
        sign_char = cls.is_space || cls.is_minus || cls.is_plus;
        pref_base = (number_base == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : number_base;
        zero_base = (base_reg == aip_pkg::BASE_HEX) ? aip_pkg::BASE_HEX : aip_pkg::BASE_OCT;
        do_digit  = 1'b0;
        dbase     = base_reg;
        unique case (phase_reg)
            aip_pkg::PH_SPACE:
            begin
                do_digit = !sign_char && !zero_pref;
                dbase    = pref_base;
            end
            aip_pkg::PH_SIGN:
            begin
                do_digit = !zero_pref;
                dbase    = pref_base;
            end
            aip_pkg::PH_ZERO:
            begin
                do_digit = !cls.is_x;
                dbase    = zero_base;
            end
            aip_pkg::PH_DIGITS:
            begin
                do_digit = 1'b1;
                dbase    = base_reg;
            end
            default:
            begin
                do_digit = 1'b0;
                dbase    = base_reg;
            end
        endcase
        dig_ok = cls.is_digit && (cls.digit < dbase);
        take   = do_digit && dig_ok;
        mac    = PROD_BITS'(acc_reg) * PROD_BITS'(dbase) + PROD_BITS'(cls.digit);
    end

    // Next phase of the parse.
    always_comb
    begin
        unique case (phase_reg)
            aip_pkg::PH_SPACE:
            begin
                if (cls.is_space)
                    step_phase = aip_pkg::PH_SPACE;
                else if (cls.is_minus || cls.is_plus)
                    step_phase = aip_pkg::PH_SIGN;
                else if (zero_pref)
                    step_phase = aip_pkg::PH_ZERO;
                else
                    step_phase = dig_ok ? aip_pkg::PH_DIGITS : aip_pkg::PH_STOP;
            end
            aip_pkg::PH_SIGN:
            begin
                if (zero_pref)
                    step_phase = aip_pkg::PH_ZERO;
                else
                    step_phase = dig_ok ? aip_pkg::PH_DIGITS : aip_pkg::PH_STOP;
            end
            aip_pkg::PH_ZERO:
                step_phase = (cls.is_x || dig_ok) ? aip_pkg::PH_DIGITS : aip_pkg::PH_STOP;
            aip_pkg::PH_DIGITS:
                step_phase = dig_ok ? aip_pkg::PH_DIGITS : aip_pkg::PH_STOP;
            default:
                step_phase = aip_pkg::PH_STOP;
        endcase

        if (!step)
            phase_next = phase_reg;
        else if (last)
            phase_next = aip_pkg::PH_SPACE;
        else
            phase_next = step_phase;
    end

    // Data state and the result of a final character.
    always_comb
    begin
        step_base = base_reg;
        step_neg  = neg_reg;
        step_seen = seen_reg || take;
        step_stop = stop_reg;
        step_acc  = take ? mac[VALUE_BITS-1:0] : acc_reg;
        unique case (phase_reg)
            aip_pkg::PH_SPACE:
            begin
                if (sign_char)
                begin
                    step_stop = consumed;
                    step_neg  = neg_reg || cls.is_minus;
                end
                else
                begin
                    step_base = zero_pref ? number_base : pref_base;
                    if (zero_pref)
                        step_stop = consumed;
                end
            end
            aip_pkg::PH_SIGN:
            begin
                step_base = zero_pref ? number_base : pref_base;
                if (zero_pref)
                    step_stop = consumed;
            end
            aip_pkg::PH_ZERO:
            begin
                if (cls.is_x)
                begin
                    step_base = aip_pkg::BASE_HEX;
                    step_stop = consumed;
                end
                else
                begin
                    step_base = zero_base;
                    step_seen = seen_reg || take || (base_reg == aip_pkg::BASE_HEX);
                end
            end
            default:
            begin
                step_base = base_reg;
            end
        endcase
        if (take)
            step_stop = consumed;

        res_seen   = step_seen ||
                     ((step_phase == aip_pkg::PH_ZERO) && (step_base == aip_pkg::BASE_HEX));
        res_value  = step_neg ? (~step_acc + VALUE_BITS'(1)) : step_acc;
        res_offset = res_seen ? step_stop : '0;
        res_digits = res_seen;

        if (step && last)
        begin
            acc_next  = '0;
            neg_next  = 1'b0;
            base_next = aip_pkg::BASE_AUTO;
            seen_next = 1'b0;
            cnt_next  = '0;
            stop_next = '0;
        end
        else if (step)
        begin
            acc_next  = step_acc;
            neg_next  = step_neg;
            base_next = step_base;
            seen_next = step_seen;
            cnt_next  = consumed;
            stop_next = step_stop;
        end
        else
        begin
            acc_next  = acc_reg;
            neg_next  = neg_reg;
            base_next = base_reg;
            seen_next = seen_reg;
            cnt_next  = cnt_reg;
            stop_next = stop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aip_pkg::PH_SPACE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= aip_pkg::BASE_AUTO;
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
            stop_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

@@ tb/ascii_integer_parser_tb.sv @@
// Self-checking testbench for the streaming ASCII integer parser.
module ascii_integer_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aip_pkg::*;

    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          PHASE_WORDS = 160;
    localparam int          RANDOM_SLOT = 9;
    localparam logic [7:0]  CH_NUL      = 8'h00;
    localparam logic [7:0]  NOT_DIGIT   = 8'hFF;
    localparam logic [7:0]  CH_TOP      = 8'hFF;
    localparam logic [15:0] COUNT_TOP   = 16'hFFFF;
    localparam logic [7:0]  BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    localparam logic [5:0]  BASE_PLAN [11] = '{BASE_AUTO, BASE_HEX, BASE_DEC, BASE_OCT,
                                               6'd1, 6'd2, 6'd36, 6'd37, 6'd63,
                                               BASE_AUTO, BASE_AUTO};

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    typedef struct {
        logic [VALUE_BITS_DEF-1:0] value;
        logic [COUNT_BITS_DEF-1:0] end_offset;
        logic                      any_digits;
    } parse_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [5:0]                number_base = BASE_AUTO;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                ch = CH_NUL;
    logic                      last = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VALUE_BITS_DEF-1:0] value;
    logic [COUNT_BITS_DEF-1:0] end_offset;
    logic                      any_digits;

    char_word_t    char_queue[$];
    parse_result_t parse_results_due[$];
    int            words_queued = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            in_gap = 0;
    int            out_gap = 0;
    bit            idling = 1'b1;
    char_word_t    drv_word;
    parse_result_t mon_exp;

    // Parser state as the predictor sees it.
    logic [5:0]                cur_base = BASE_AUTO;
    phase_t                    pstate;
    logic [VALUE_BITS_DEF-1:0] accum;
    logic                      minus_seen;
    logic [5:0]                radix;
    logic                      got_digit;
    logic [COUNT_BITS_DEF-1:0] char_idx;
    logic [COUNT_BITS_DEF-1:0] consumed_upto;

    ascii_integer_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .number_base (number_base),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .end_offset  (end_offset),
        .any_digits  (any_digits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | CH_CASE;
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (folded >= CH_LOW_A && folded <= CH_LOW_Z)
            return folded - CH_LOW_A + LETTER_OFFSET;
        return NOT_DIGIT;
    endfunction

    task automatic restart_string();
        pstate        = PH_SPACE;
        accum         = '0;
        minus_seen    = 1'b0;
        radix         = BASE_AUTO;
        got_digit     = 1'b0;
        char_idx      = '0;
        consumed_upto = '0;
    endtask

    task automatic accept_digit(input logic [7:0] c, input logic [15:0] upto);
        logic [7:0] d;
        d = digit_value(c);
        if (c == CH_NUL || d == NOT_DIGIT || d >= radix)
        begin
            pstate = PH_STOP;
        end
        else
        begin
            accum         = accum * VALUE_BITS_DEF'(radix) + VALUE_BITS_DEF'(d);
            got_digit     = 1'b1;
            consumed_upto = upto;
        end
    endtask

    task automatic start_number(input logic [7:0] c, input logic [15:0] upto);
        if (c == CH_ZERO && (cur_base == BASE_AUTO || cur_base == BASE_HEX))
        begin
            radix         = cur_base;
            pstate        = PH_ZERO;
            consumed_upto = upto;
        end
        else
        begin
            radix  = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
            pstate = PH_DIGITS;
            accept_digit(c, upto);
        end
    endtask

    task automatic settle_zero();
        if (radix == BASE_HEX)
            got_digit = 1'b1;
        else
            radix = BASE_OCT;
        pstate = PH_DIGITS;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic lst);
        logic [15:0]   upto;
        parse_result_t r;
        upto = (char_idx == COUNT_TOP) ? COUNT_TOP : char_idx + 16'd1;
        case (pstate)
            PH_SPACE:
            begin
                if (is_blank(c))
                begin
                    consumed_upto = upto;
                end
                else if (c == CH_MINUS)
                begin
                    minus_seen    = 1'b1;
                    pstate        = PH_SIGN;
                    consumed_upto = upto;
                end
                else if (c == CH_PLUS)
                begin
                    pstate        = PH_SIGN;
                    consumed_upto = upto;
                end
                else
                begin
                    start_number(c, upto);
                end
            end
            PH_SIGN:
                start_number(c, upto);
            PH_ZERO:
            begin
                if ((c | CH_CASE) == CH_LOW_X)
                begin
                    radix         = BASE_HEX;
                    pstate        = PH_DIGITS;
                    consumed_upto = upto;
                end
                else
                begin
                    settle_zero();
                    accept_digit(c, upto);
                end
            end
            PH_DIGITS:
                accept_digit(c, upto);
            default:
                pstate = PH_STOP;
        endcase
        char_idx = upto;
        if (lst)
        begin
            if (pstate == PH_ZERO)
                settle_zero();
            r.value      = minus_seen ? -accum : accum;
            r.end_offset = got_digit ? consumed_upto : '0;
            r.any_digits = got_digit;
            parse_results_due.push_back(r);
            restart_string();
        end
    endtask

    task automatic add_char(input logic [7:0] c, input logic lst);
        char_word_t w;
        w.ch   = c;
        w.last = lst;
        char_queue.push_back(w);
        words_queued++;
    endtask

    task automatic add_text(input string s, input logic closes);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], closes && i == s.len() - 1);
    endtask

    function automatic logic [7:0] digit_char(input logic [5:0] r);
        int         lim;
        int         d;
        logic [7:0] letter_a;
        lim      = (r == 6'd0) ? 1 : ((int'(r) > 36) ? 36 : int'(r));
        d        = $urandom_range(0, lim - 1);
        letter_a = $urandom_range(0, 1) ? CH_LOW_A : (CH_LOW_A & ~CH_CASE);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return letter_a + 8'(d) - LETTER_OFFSET;
    endfunction

    task automatic random_string();
        logic [7:0] chars[$];
        logic [5:0] r;
        r = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3)) chars.push_back(BLANKS[$urandom_range(0, 5)]);
            case ($urandom_range(0, 3))
                0: chars.push_back(CH_MINUS);
                1: chars.push_back(CH_PLUS);
                default: ;
            endcase
            if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && $urandom_range(0, 2) == 0)
            begin
                chars.push_back(CH_ZERO);
                if ($urandom_range(0, 2) != 0)
                begin
                    chars.push_back($urandom_range(0, 1) ? CH_LOW_X : (CH_LOW_X & ~CH_CASE));
                    r = BASE_HEX;
                end
                else if (cur_base == BASE_AUTO)
                begin
                    r = BASE_OCT;
                end
            end
            repeat ($urandom_range(0, 12)) chars.push_back(digit_char(r));
            case ($urandom_range(0, 3))
                0: chars.push_back(8'($urandom_range(0, 255)));
                1: chars.push_back(CH_NUL);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
        end
        if (chars.size() == 0)
            chars.push_back(digit_char(r));
        foreach (chars[i])
            add_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic wait_idle();
        while (char_queue.size() != 0 || in_valid || parse_results_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        wait_idle();
        @(posedge clk);
        cfg_valid   <= 1'b1;
        number_base <= b;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_base = b;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch       <= CH_NUL;
            last     <= 1'b0;
            in_gap   = 0;
            restart_string();
        end
        else
        begin
            if (in_valid && in_ready)
                parse_char(ch, last);
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    drv_word = char_queue.pop_front();
                    in_valid <= 1'b1;
                    ch       <= drv_word.ch;
                    last     <= drv_word.last;
                    if (idling && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (parse_results_due.size() == 0)
                begin
                    $error("result word with nothing pending: value %0h", value);
                    mismatches++;
                end
                else
                begin
                    mon_exp = parse_results_due.pop_front();
                    if (value !== mon_exp.value)
                    begin
                        $error("value: expected %0h, actual %0h", mon_exp.value, value);
                        mismatches++;
                    end
                    if (end_offset !== mon_exp.end_offset)
                    begin
                        $error("end_offset: expected %0d, actual %0d",
                               mon_exp.end_offset, end_offset);
                        mismatches++;
                    end
                    if (any_digits !== mon_exp.any_digits)
                    begin
                        $error("any_digits: expected %0b, actual %0b",
                               mon_exp.any_digits, any_digits);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_gap = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int mark;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Automatic base: lone zero, bare prefix, hex, blanks with sign, octal stop,
        // zero byte mid-string and the top character code; hex base: 0g and a bare sign.
        write_base(BASE_AUTO);
        add_text("0", 1'b1);
        add_text("0x", 1'b1);
        add_text("-0xfF", 1'b1);
        foreach (BLANKS[i])
            add_char(BLANKS[i], 1'b0);
        add_text("+017", 1'b1);
        add_text("09", 1'b1);
        add_text("1", 1'b0);
        add_char(CH_NUL, 1'b0);
        add_text("2", 1'b1);
        add_char(CH_TOP, 1'b1);
        write_base(BASE_HEX);
        add_text("0g", 1'b1);
        add_text("+", 1'b1);

        for (int p = 0; p < 11; p++)
        begin
            write_base(p == RANDOM_SLOT ? 6'($urandom_range(0, 63)) : BASE_PLAN[p]);
            idling = (p != 10);
            mark = words_queued;
            while (words_queued - mark < PHASE_WORDS)
                random_string();
        end

        wait_idle();
        if (mismatches == 0 && parse_results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
